>>> sv/bpc_pkg.sv
// shared types and register codes for the barometric compensation block
// no dependencies

package bpc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_ORDER     = 3'd6;

	localparam logic signed [18:0] TEMP_NOMINAL = 19'sd2000;
	localparam logic signed [18:0] TEMP_COLD    = -19'sd1500;
	localparam logic signed [19:0] TEMP_MIN     = -20'sd262144;
	localparam logic signed [19:0] TEMP_MAX     = 20'sd262143;
	localparam logic signed [29:0] PRES_MAX     = 30'sd262143;

	typedef struct packed {
		logic [15:0] pressure_sens;
		logic [15:0] pressure_offset;
		logic [15:0] sens_temp_coef;
		logic [15:0] offset_temp_coef;
		logic [15:0] ref_temp;
		logic [15:0] temp_coef;
		logic        second_order;
	} cfg_t;

	// first-order results, signed fields held as plain vectors
	typedef struct packed {
		logic        valid;
		logic [23:0] d1;
		logic [18:0] temp;
		logic [16:0] t2;
		logic [34:0] off;
		logic [34:0] sens;
	} front_t;

	// corrected offset, sensitivity and final temperature
	typedef struct packed {
		logic        valid;
		logic [23:0] d1;
		logic [18:0] temp;
		logic [39:0] off;
		logic [39:0] sens;
	} corr_t;

endpackage

>>> sv/bpc_cfg_regs.sv
// calibration word and mode registers behind the plain write port
// depends on bpc_pkg

module bpc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output bpc_pkg::cfg_t                    cfg
);
	import bpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESSURE_SENS:    cfg_q.pressure_sens    <= cfg_wdata;
				REG_PRESSURE_OFFSET:  cfg_q.pressure_offset  <= cfg_wdata;
				REG_SENS_TEMP_COEF:   cfg_q.sens_temp_coef   <= cfg_wdata;
				REG_OFFSET_TEMP_COEF: cfg_q.offset_temp_coef <= cfg_wdata;
				REG_REF_TEMP:         cfg_q.ref_temp         <= cfg_wdata;
				REG_TEMP_COEF:        cfg_q.temp_coef        <= cfg_wdata;
				REG_SECOND_ORDER:     cfg_q.second_order     <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/bpc_front.sv
// stages 1 to 3: temperature difference, coefficient products, first-order terms
// depends on bpc_pkg

module bpc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [23:0]    raw_pressure,
	input  logic [23:0]    raw_temperature,
	input  bpc_pkg::cfg_t  cfg,
	output bpc_pkg::front_t front
);
	import bpc_pkg::*;

	logic               valid_s1, valid_s2, valid_s3;
	logic [23:0]        d1_s1, d1_s2, d1_s3;
	logic signed [24:0] dt_s1;
	logic signed [41:0] mt_s2, mo_s2, ms_s2;
	logic signed [49:0] msq_s2;
	logic [18:0]        temp_s3;
	logic [16:0]        t2_s3;
	logic [34:0]        off_s3, sens_s3;

	logic signed [41:0] mt_adj, mo_adj, ms_adj;
	logic signed [34:0] off_w, sens_w;
	logic [18:0]        temp_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: dT
	always_ff @(posedge clk) begin
		d1_s1 <= raw_pressure;
		dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.ref_temp, 8'h00});
	end

	// stage 2: products with dT
	always_ff @(posedge clk) begin
		d1_s2  <= d1_s1;
		mt_s2  <= dt_s1 * $signed({1'b0, cfg.temp_coef});
		mo_s2  <= dt_s1 * $signed({1'b0, cfg.offset_temp_coef});
		ms_s2  <= dt_s1 * $signed({1'b0, cfg.sens_temp_coef});
		msq_s2 <= dt_s1 * dt_s1;
	end

	// stage 3: divisions truncate toward zero by biasing negative values
	assign mt_adj = mt_s2 + $signed({19'd0, {23{mt_s2[41]}}});
	assign mo_adj = mo_s2 + $signed({35'd0, {7{mo_s2[41]}}});
	assign ms_adj = ms_s2 + $signed({34'd0, {8{ms_s2[41]}}});

	assign temp_w = mt_adj[41:23] + TEMP_NOMINAL;
	assign off_w  = $signed({3'b000, cfg.pressure_offset, 16'h0000}) + $signed(mo_adj[41:7]);
	assign sens_w = $signed({4'h0, cfg.pressure_sens, 15'h0000})
		+ $signed({ms_adj[41], ms_adj[41:8]});

	always_ff @(posedge clk) begin
		d1_s3   <= d1_s2;
		temp_s3 <= temp_w;
		t2_s3   <= msq_s2[47:31];
		off_s3  <= off_w;
		sens_s3 <= sens_w;
	end

	assign front.valid = valid_s3;
	assign front.d1    = d1_s3;
	assign front.temp  = temp_s3;
	assign front.t2    = t2_s3;
	assign front.off   = off_s3;
	assign front.sens  = sens_s3;

endmodule

>>> sv/bpc_corr.sv
// stages 4 and 5: low-temperature second-order corrections
// depends on bpc_pkg

module bpc_corr (
	input  logic            clk,
	input  logic            arst_n,
	input  bpc_pkg::cfg_t   cfg,
	input  bpc_pkg::front_t front,
	output bpc_pkg::corr_t  corr
);
	import bpc_pkg::*;

	logic               valid_s4, valid_s5;
	logic [23:0]        d1_s4, d1_s5;
	logic [18:0]        temp_s4, temp_s5;
	logic signed [34:0] off_s4;
	logic signed [34:0] sens_s4;
	logic signed [39:0] aa_s4, bb_s4;
	logic               so_s4, cold_s4;
	logic [39:0]        off_s5, sens_s5;

	logic signed [19:0] a_w, b_w, t_ext, t_corr, t_sat;
	logic [34:0]        aa_u, bb_u;
	logic [37:0]        five_aa, seven_bb;
	logic [38:0]        eleven_bb, off2, sens2;
	logic signed [39:0] off_c, sens_c;

	assign t_ext  = $signed({front.temp[18], front.temp});
	assign a_w    = t_ext - 20'sd2000;
	assign b_w    = t_ext + 20'sd1500;
	assign t_corr = t_ext - $signed({3'b000, front.t2});

	always_comb begin
		if (t_corr < TEMP_MIN) begin
			t_sat = TEMP_MIN;
		end else if (t_corr > TEMP_MAX) begin
			t_sat = TEMP_MAX;
		end else begin
			t_sat = t_corr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= front.valid;
			valid_s5 <= valid_s4;
		end
	end

	// stage 4: squares and correction selects
	always_ff @(posedge clk) begin
		d1_s4   <= front.d1;
		off_s4  <= $signed(front.off);
		sens_s4 <= $signed(front.sens);
		aa_s4   <= a_w * a_w;
		bb_s4   <= b_w * b_w;
		so_s4   <= cfg.second_order && ($signed(front.temp) < TEMP_NOMINAL);
		cold_s4 <= $signed(front.temp) < TEMP_COLD;
		if (cfg.second_order && ($signed(front.temp) < TEMP_NOMINAL)) begin
			temp_s4 <= t_sat[18:0];
		end else begin
			temp_s4 <= front.temp;
		end
	end

	// stage 5: squares are nonnegative, so halving is a shift
	assign aa_u      = aa_s4[34:0];
	assign bb_u      = bb_s4[34:0];
	assign five_aa   = {1'b0, aa_u, 2'b00} + {3'b000, aa_u};
	assign seven_bb  = {bb_u, 3'b000} - {3'b000, bb_u};
	assign eleven_bb = {1'b0, bb_u, 3'b000} + {3'b000, bb_u, 1'b0} + {4'h0, bb_u};
	assign off2      = {2'b00, five_aa[37:1]} + (cold_s4 ? {1'b0, seven_bb} : 39'd0);
	assign sens2     = {3'b000, five_aa[37:2]} + (cold_s4 ? {1'b0, eleven_bb[38:1]} : 39'd0);
	assign off_c     = {{5{off_s4[34]}}, off_s4} - $signed({1'b0, off2});
	assign sens_c    = {{5{sens_s4[34]}}, sens_s4} - $signed({1'b0, sens2});

	always_ff @(posedge clk) begin
		d1_s5   <= d1_s4;
		temp_s5 <= temp_s4;
		if (so_s4) begin
			off_s5  <= off_c;
			sens_s5 <= sens_c;
		end else begin
			off_s5  <= {{5{off_s4[34]}}, off_s4};
			sens_s5 <= {{5{sens_s4[34]}}, sens_s4};
		end
	end

	assign corr.valid = valid_s5;
	assign corr.d1    = d1_s5;
	assign corr.temp  = temp_s5;
	assign corr.off   = off_s5;
	assign corr.sens  = sens_s5;

endmodule

>>> sv/bpc_pres.sv
// stages 6 to 8: split pressure product, scaling and output saturation
// depends on bpc_pkg

module bpc_pres (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpc_pkg::corr_t        corr,
	output logic                  done,
	output logic signed [18:0]    temperature_centi,
	output logic [17:0]           pressure_pa
);
	import bpc_pkg::*;

	logic               valid_s6, valid_s7, done_q;
	logic [18:0]        temp_s6, temp_s7, temp_q;
	logic [39:0]        off_s6, off_s7;
	logic [43:0]        plo_s6;
	logic signed [44:0] phi_s6;
	logic signed [43:0] q_s7;
	logic [17:0]        pres_q;

	logic signed [64:0] prod, prod_adj;
	logic signed [44:0] r_w, r_adj;
	logic signed [29:0] p_w;
	logic [17:0]        p_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s6 <= corr.valid;
			valid_s7 <= valid_s6;
			done_q   <= valid_s7;
		end
	end

	// stage 6: D1 times SENS as two partial products
	always_ff @(posedge clk) begin
		temp_s6 <= corr.temp;
		off_s6  <= corr.off;
		plo_s6  <= corr.d1 * corr.sens[19:0];
		phi_s6  <= $signed({1'b0, corr.d1}) * $signed(corr.sens[39:20]);
	end

	// stage 7: recombine, divide by 2^21 toward zero
	assign prod     = $signed({phi_s6, 20'd0}) + $signed({21'd0, plo_s6});
	assign prod_adj = prod + $signed({44'd0, {21{prod[64]}}});

	always_ff @(posedge clk) begin
		temp_s7 <= temp_s6;
		off_s7  <= off_s6;
		q_s7    <= prod_adj[64:21];
	end

	// stage 8: subtract offset, divide by 2^15 toward zero, saturate
	assign r_w   = {q_s7[43], q_s7} - {{5{off_s7[39]}}, off_s7};
	assign r_adj = r_w + $signed({30'd0, {15{r_w[44]}}});
	assign p_w   = r_adj[44:15];

	always_comb begin
		if (p_w < 30'sd0) begin
			p_sat = '0;
		end else if (p_w > PRES_MAX) begin
			p_sat = PRES_MAX[17:0];
		end else begin
			p_sat = p_w[17:0];
		end
	end

	always_ff @(posedge clk) begin
		temp_q <= temp_s7;
		pres_q <= p_sat;
	end

	assign done              = done_q;
	assign temperature_centi = $signed(temp_q);
	assign pressure_pa       = pres_q;

endmodule

>>> sv/baro_pressure_temp_compensation_top.sv
// Barometric pressure and temperature compensation, eight-stage pipeline.
// A reading pair is taken at every clock edge where start is high; busy is
// always low, so one pair can be issued each cycle. Each pair produces one
// result, shown on done for a single cycle with temperature_centi and
// pressure_pa; the receiver has no way to stall, so it must take every
// result on the cycle it is shown. The latency is set by the multiplier
// stages: the dT products, the squares of the second-order terms and the
// split 24 by 40 bit pressure product.
// Calibration words are to be written by the user through cfg_we, cfg_index
// and cfg_wdata while no reading is in flight; the block does not enforce it.
// depends on bpc_pkg, bpc_cfg_regs, bpc_front, bpc_corr, bpc_pres

module baro_pressure_temp_compensation_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [23:0]                    raw_pressure,
	input  logic [23:0]                    raw_temperature,
	output logic                           done,
	output logic signed [18:0]             temperature_centi,
	output logic [17:0]                    pressure_pa,
	input  logic                           cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bpc_pkg::*;

	cfg_t   cfg;
	front_t front;
	corr_t  corr;

	assign busy = 1'b0;

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bpc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (start & ~busy),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.cfg             (cfg),
		.front           (front)
	);

	bpc_corr u_corr (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.front  (front),
		.corr   (corr)
	);

	bpc_pres u_pres (
		.clk               (clk),
		.arst_n            (arst_n),
		.corr              (corr),
		.done              (done),
		.temperature_centi (temperature_centi),
		.pressure_pa       (pressure_pa)
	);

endmodule
